FILE: design/binarize_majority_downscale_macros.svh
// Assertion shorthands used by the checker file of this block.
`ifndef BINARIZE_MAJORITY_DOWNSCALE_MACROS_SVH
`define BINARIZE_MAJORITY_DOWNSCALE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMD_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BMD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bmd_pkg.sv
`default_nettype none

package bmd_pkg;

   localparam int MAX_SRC_DIM_DEF    = 1024;
   localparam int MAX_DST_HEIGHT_DEF = 32;
   localparam int MAX_DST_WIDTH_DEF  = 32;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int PIX_W       = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int CELL_W      = 5;
   localparam int RSP_TDATA_W = 16;

   localparam int SRC_CFG_W = 11;
   localparam int DST_CFG_W = 6;
   localparam int THR_W     = 8;

   localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST     = 11'd240;
   localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST      = 11'd160;
   localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST     = 6'd24;
   localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST      = 6'd16;
   localparam logic [THR_W-1:0]     LUMA_THRESHOLD_RST = 8'd200;

   localparam int LUMA_W      = 22;
   localparam int LUMA_COEF_R = 2989;
   localparam int LUMA_COEF_G = 5870;
   localparam int LUMA_COEF_B = 1140;
   localparam int LUMA_SCALE  = 10000;

   typedef enum logic [2:0] {
      REG_SRC_HEIGHT     = 3'd0,
      REG_SRC_WIDTH      = 3'd1,
      REG_DST_HEIGHT     = 3'd2,
      REG_DST_WIDTH      = 3'd3,
      REG_LUMA_THRESHOLD = 3'd4
   } bmd_reg_type;

endpackage

`default_nettype wire

FILE: design/binarize_majority_downscale.sv
// Binarizes an RGB pixel stream and shrinks it to a small bitmap by majority
// vote over box windows.
// Pixels enter on the req channel in raster order, one transaction per pixel.
// A pixel that closes an output cell produces one transaction on the rsp
// channel carrying the cell value, its row and column; tlast marks the last
// cell of the frame. Other pixels produce nothing.
// Throughput is one pixel per clock while req_tready is high. A pixel that
// closes a cell is registered into the tally stage while the column memory
// reads its tally; the read-modify-write then queues the result for output.
// Results wait in a two-entry output queue. When the queue is full and the
// pixel in the tally stage closes a cell, req_tready drops until the receiver
// takes a result.
// Reset loads the default sizes and threshold, restarts the frame and marks
// every column tally as zero through per-column valid bits, so no clearing
// pass is needed. Writing any size register restarts the frame the same way;
// the threshold register takes effect on the next pixel.
// Registers sit on the APB port at byte address 4*index and read back.
`default_nettype none

module binarize_majority_downscale #(
   parameter int MAX_SRC_DIM    = bmd_pkg::MAX_SRC_DIM_DEF,
   parameter int MAX_DST_HEIGHT = bmd_pkg::MAX_DST_HEIGHT_DEF,
   parameter int MAX_DST_WIDTH  = bmd_pkg::MAX_DST_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bmd_pkg::REQ_TDATA_W-1:0]  req_tdata,  // red, green, blue
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bmd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // cell_bit, cell_row, cell_col
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bmd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bmd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int SDIM_W  = $clog2(MAX_SRC_DIM + 1);
   localparam int SPOS_W  = $clog2(MAX_SRC_DIM);
   localparam int DH_W    = $clog2(MAX_DST_HEIGHT + 1);
   localparam int DW_W    = $clog2(MAX_DST_WIDTH + 1);
   localparam int DROW_W  = (MAX_DST_HEIGHT > 1) ? $clog2(MAX_DST_HEIGHT) : 1;
   localparam int DCOL_W  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
   localparam int MAX_DST = (MAX_DST_HEIGHT > MAX_DST_WIDTH) ? MAX_DST_HEIGHT
                                                             : MAX_DST_WIDTH;
   localparam int CNT_W   = $clog2(2 * (MAX_SRC_DIM + 1) * (MAX_DST + 2));
   localparam int CNT_X_W = CNT_W + 1;
   localparam int TALLY_W = $clog2(MAX_SRC_DIM * MAX_SRC_DIM) + 2;
   localparam int LUMA_W  = bmd_pkg::LUMA_W;
   localparam int CELL_W  = bmd_pkg::CELL_W;
   localparam int PIX_W   = bmd_pkg::PIX_W;

   typedef struct packed {
      logic              frame_done;
      logic [CELL_W-1:0] cell_col;
      logic [CELL_W-1:0] cell_row;
      logic              cell_bit;
   } bmd_result_type;

   function automatic logic [31:0] clamp_dim(input logic [31:0] value,
                                             input logic [31:0] hi);
      if (value < 32'd1) begin
         return 32'd1;
      end
      if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   // Configuration registers
   logic [bmd_pkg::SRC_CFG_W-1:0] src_height_ff, src_height_in;
   logic [bmd_pkg::SRC_CFG_W-1:0] src_width_ff, src_width_in;
   logic [bmd_pkg::DST_CFG_W-1:0] dst_height_ff, dst_height_in;
   logic [bmd_pkg::DST_CFG_W-1:0] dst_width_ff, dst_width_in;
   logic [bmd_pkg::THR_W-1:0]     thr_ff, thr_in;
   logic [LUMA_W-1:0]             thr_scaled_ff, thr_scaled_in;

   logic                  csr_wr;
   logic                  size_wr;
   logic                  restart_all;
   bmd_pkg::bmd_reg_type  reg_idx;

   // Effective sizes
   logic [31:0]       sh_w, sw_w, dh_w, dw_w, dh_lim, dw_lim;
   logic [SDIM_W-1:0] eff_sh_ff, eff_sh_in, eff_sw_ff, eff_sw_in;
   logic [DH_W-1:0]   eff_dh_ff, eff_dh_in;
   logic [DW_W-1:0]   eff_dw_ff, eff_dw_in;

   // Frame counters
   logic [SPOS_W-1:0] src_row_ff, src_row_in, src_col_ff, src_col_in;
   logic [DROW_W-1:0] dst_row_ff, dst_row_in;
   logic [DCOL_W-1:0] dst_col_ff, dst_col_in;
   logic [CNT_W-1:0]  row_edge_ff, row_edge_in, row_pos_ff, row_pos_in;
   logic [CNT_W-1:0]  col_edge_ff, col_edge_in, col_pos_ff, col_pos_in;
   logic [CNT_W-1:0]  row_edge_rst, row_pos_rst, col_edge_rst, col_pos_rst;
   logic [CNT_W-1:0]  two_sh, two_sw, two_dh, two_dw;
   logic              row_last, col_last, row_end, frame_end, cell_done;

   logic              accept;
   logic [LUMA_W-1:0] luma;

   // Tally stage
   logic              b_valid_ff, b_valid_in;
   logic              b_one_ff, b_emit_ff, b_done_ff;
   logic [DCOL_W-1:0] b_col_ff;
   logic [DROW_W-1:0] b_row_ff;
   logic              b_stall, b_advance;

   logic [MAX_DST_WIDTH-1:0] valid_ff, valid_in;
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [DCOL_W-1:0]        fwd_addr_ff;
   logic [TALLY_W-1:0]       fwd_data_ff;

   logic [TALLY_W-1:0]        ram_rd_data, ram_wr_data;
   logic signed [TALLY_W-1:0] tally_old, tally_new;
   logic                      tally_pos;

   // Output queue
   bmd_result_type q_ff [2];
   bmd_result_type q_in [2];
   bmd_result_type new_result;
   logic [1:0]     out_cnt_ff, out_cnt_in, out_slot;
   logic           push, pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = bmd_pkg::bmd_reg_type'(csr_paddr[bmd_pkg::CSR_ADDR_W-1:2]);
   assign size_wr    = csr_wr && (reg_idx inside {bmd_pkg::REG_SRC_HEIGHT,
                                                  bmd_pkg::REG_SRC_WIDTH,
                                                  bmd_pkg::REG_DST_HEIGHT,
                                                  bmd_pkg::REG_DST_WIDTH});
   assign restart_all = reset || size_wr;

   always_comb begin
      src_height_in = src_height_ff;
      src_width_in  = src_width_ff;
      dst_height_in = dst_height_ff;
      dst_width_in  = dst_width_ff;
      thr_in        = thr_ff;
      if (reset) begin
         src_height_in = bmd_pkg::SRC_HEIGHT_RST;
         src_width_in  = bmd_pkg::SRC_WIDTH_RST;
         dst_height_in = bmd_pkg::DST_HEIGHT_RST;
         dst_width_in  = bmd_pkg::DST_WIDTH_RST;
         thr_in        = bmd_pkg::LUMA_THRESHOLD_RST;
      end else if (csr_wr) begin
         case (reg_idx)
            bmd_pkg::REG_SRC_HEIGHT:     src_height_in = csr_pwdata[bmd_pkg::SRC_CFG_W-1:0];
            bmd_pkg::REG_SRC_WIDTH:      src_width_in  = csr_pwdata[bmd_pkg::SRC_CFG_W-1:0];
            bmd_pkg::REG_DST_HEIGHT:     dst_height_in = csr_pwdata[bmd_pkg::DST_CFG_W-1:0];
            bmd_pkg::REG_DST_WIDTH:      dst_width_in  = csr_pwdata[bmd_pkg::DST_CFG_W-1:0];
            bmd_pkg::REG_LUMA_THRESHOLD: thr_in        = csr_pwdata[bmd_pkg::THR_W-1:0];
            default: ;
         endcase
      end
      thr_scaled_in = LUMA_W'(thr_in) * LUMA_W'(bmd_pkg::LUMA_SCALE);
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         bmd_pkg::REG_SRC_HEIGHT:     csr_prdata = bmd_pkg::CSR_DATA_W'(src_height_ff);
         bmd_pkg::REG_SRC_WIDTH:      csr_prdata = bmd_pkg::CSR_DATA_W'(src_width_ff);
         bmd_pkg::REG_DST_HEIGHT:     csr_prdata = bmd_pkg::CSR_DATA_W'(dst_height_ff);
         bmd_pkg::REG_DST_WIDTH:      csr_prdata = bmd_pkg::CSR_DATA_W'(dst_width_ff);
         bmd_pkg::REG_LUMA_THRESHOLD: csr_prdata = bmd_pkg::CSR_DATA_W'(thr_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      sh_w   = clamp_dim(32'(src_height_in), 32'(MAX_SRC_DIM));
      sw_w   = clamp_dim(32'(src_width_in), 32'(MAX_SRC_DIM));
      dh_lim = (sh_w < 32'(MAX_DST_HEIGHT)) ? sh_w : 32'(MAX_DST_HEIGHT);
      dw_lim = (sw_w < 32'(MAX_DST_WIDTH)) ? sw_w : 32'(MAX_DST_WIDTH);
      dh_w   = clamp_dim(32'(dst_height_in), dh_lim);
      dw_w   = clamp_dim(32'(dst_width_in), dw_lim);
      eff_sh_in = sh_w[SDIM_W-1:0];
      eff_sw_in = sw_w[SDIM_W-1:0];
      eff_dh_in = dh_w[DH_W-1:0];
      eff_dw_in = dw_w[DW_W-1:0];
      row_edge_rst = (CNT_W'(eff_sh_in) << 1) + CNT_W'(eff_dh_in);
      row_pos_rst  = CNT_W'(eff_dh_in) << 1;
      col_edge_rst = (CNT_W'(eff_sw_in) << 1) + CNT_W'(eff_dw_in);
      col_pos_rst  = CNT_W'(eff_dw_in) << 1;
   end

   assign accept     = req_tvalid && req_tready;
   assign b_stall    = b_valid_ff && b_emit_ff && (out_cnt_ff == 2'd2);
   assign b_advance  = b_valid_ff && !b_stall;
   assign req_tready = !reset && !b_stall;

   assign two_sh = CNT_W'(eff_sh_ff) << 1;
   assign two_sw = CNT_W'(eff_sw_ff) << 1;
   assign two_dh = CNT_W'(eff_dh_ff) << 1;
   assign two_dw = CNT_W'(eff_dw_ff) << 1;

   assign row_last  = (CNT_X_W'(row_pos_ff) + CNT_X_W'(two_dh)) > CNT_X_W'(row_edge_ff);
   assign col_last  = (CNT_X_W'(col_pos_ff) + CNT_X_W'(two_dw)) > CNT_X_W'(col_edge_ff);
   assign row_end   = (SDIM_W'(src_col_ff) + SDIM_W'(1)) >= eff_sw_ff;
   assign frame_end = row_end && ((SDIM_W'(src_row_ff) + SDIM_W'(1)) >= eff_sh_ff);
   assign cell_done = ((DH_W'(dst_row_ff) + DH_W'(1)) >= eff_dh_ff)
                   && ((DW_W'(dst_col_ff) + DW_W'(1)) >= eff_dw_ff);

   assign luma = LUMA_W'(bmd_pkg::LUMA_COEF_R) * LUMA_W'(req_tdata[PIX_W-1:0])
               + LUMA_W'(bmd_pkg::LUMA_COEF_G) * LUMA_W'(req_tdata[2*PIX_W-1:PIX_W])
               + LUMA_W'(bmd_pkg::LUMA_COEF_B) * LUMA_W'(req_tdata[3*PIX_W-1:2*PIX_W]);

   always_comb begin
      src_row_in  = src_row_ff;
      src_col_in  = src_col_ff;
      dst_row_in  = dst_row_ff;
      dst_col_in  = dst_col_ff;
      row_edge_in = row_edge_ff;
      row_pos_in  = row_pos_ff;
      col_edge_in = col_edge_ff;
      col_pos_in  = col_pos_ff;
      if (restart_all || (accept && frame_end)) begin
         src_row_in  = '0;
         src_col_in  = '0;
         dst_row_in  = '0;
         dst_col_in  = '0;
         row_edge_in = row_edge_rst;
         row_pos_in  = row_pos_rst;
         col_edge_in = col_edge_rst;
         col_pos_in  = col_pos_rst;
      end else if (accept) begin
         if (row_end) begin
            src_col_in  = '0;
            dst_col_in  = '0;
            col_edge_in = col_edge_rst;
            col_pos_in  = col_pos_rst;
            src_row_in  = src_row_ff + SPOS_W'(1);
            row_pos_in  = row_pos_ff + two_dh;
            if (row_last) begin
               dst_row_in  = dst_row_ff + DROW_W'(1);
               row_edge_in = row_edge_ff + two_sh;
            end
         end else begin
            src_col_in = src_col_ff + SPOS_W'(1);
            col_pos_in = col_pos_ff + two_dw;
            if (col_last) begin
               dst_col_in  = dst_col_ff + DCOL_W'(1);
               col_edge_in = col_edge_ff + two_sw;
            end
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (restart_all) begin
         b_valid_in = 1'b0;
      end else if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   bmd_ram #(
      .WIDTH (TALLY_W),
      .DEPTH (MAX_DST_WIDTH)
   ) u_tally_ram (
      .clock   (clock),
      .wr_en   (b_advance),
      .wr_addr (b_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (dst_col_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == b_col_ff)) begin
         tally_old = $signed(fwd_data_ff);
      end else if (valid_ff[b_col_ff]) begin
         tally_old = $signed(ram_rd_data);
      end else begin
         tally_old = '0;
      end
      tally_new   = b_one_ff ? tally_old + TALLY_W'(1) : tally_old - TALLY_W'(1);
      tally_pos   = !tally_new[TALLY_W-1] && (tally_new != '0);
      ram_wr_data = b_emit_ff ? '0 : tally_new;
   end

   always_comb begin
      valid_in     = valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (restart_all) begin
         valid_in     = '0;
         fwd_valid_in = 1'b0;
      end else if (b_advance) begin
         valid_in[b_col_ff] = 1'b1;
         fwd_valid_in       = 1'b1;
      end
   end

   assign new_result.frame_done = b_done_ff;
   assign new_result.cell_col   = CELL_W'(b_col_ff);
   assign new_result.cell_row   = CELL_W'(b_row_ff);
   assign new_result.cell_bit   = tally_pos;

   assign push     = b_advance && b_emit_ff;
   assign pop      = rsp_tvalid && rsp_tready;
   assign out_slot = out_cnt_ff - {1'b0, pop};

   always_comb begin
      q_in[0]    = q_ff[0];
      q_in[1]    = q_ff[1];
      out_cnt_in = out_cnt_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[out_slot[0]] = new_result;
      end
      if (reset) begin
         out_cnt_in = '0;
      end
   end

   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_tdata  = bmd_pkg::RSP_TDATA_W'({q_ff[0].cell_col, q_ff[0].cell_row,
                                              q_ff[0].cell_bit});
   assign rsp_tlast  = q_ff[0].frame_done;

   always_ff @(posedge clock) begin
      src_height_ff <= src_height_in;
      src_width_ff  <= src_width_in;
      dst_height_ff <= dst_height_in;
      dst_width_ff  <= dst_width_in;
      thr_ff        <= thr_in;
      thr_scaled_ff <= thr_scaled_in;
      eff_sh_ff     <= eff_sh_in;
      eff_sw_ff     <= eff_sw_in;
      eff_dh_ff     <= eff_dh_in;
      eff_dw_ff     <= eff_dw_in;
      src_row_ff    <= src_row_in;
      src_col_ff    <= src_col_in;
      dst_row_ff    <= dst_row_in;
      dst_col_ff    <= dst_col_in;
      row_edge_ff   <= row_edge_in;
      row_pos_ff    <= row_pos_in;
      col_edge_ff   <= col_edge_in;
      col_pos_ff    <= col_pos_in;
      b_valid_ff    <= b_valid_in;
      valid_ff      <= valid_in;
      fwd_valid_ff  <= fwd_valid_in;
      out_cnt_ff    <= out_cnt_in;
      q_ff[0]       <= q_in[0];
      q_ff[1]       <= q_in[1];
      if (accept) begin
         b_one_ff  <= luma >= thr_scaled_ff;
         b_col_ff  <= dst_col_ff;
         b_row_ff  <= dst_row_ff;
         b_emit_ff <= row_last && col_last;
         b_done_ff <= cell_done;
      end
      if (b_advance) begin
         fwd_addr_ff <= b_col_ff;
         fwd_data_ff <= ram_wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/bmd_ram.sv
`default_nettype none

module bmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/bmd_checker.sv
`default_nettype none

`include "binarize_majority_downscale_macros.svh"

module bmd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [bmd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [bmd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                             rsp_tlast,
   input wire logic                             csr_psel,
   input wire logic                             csr_penable,
   input wire logic                             csr_pwrite,
   input wire logic [bmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input wire logic [bmd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input wire logic [bmd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input wire logic                             csr_pready
);

   logic req_xfer;
   logic thr_wr;
   logic thr_rd;

   assign req_xfer = req_tvalid && req_tready;
   assign thr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[bmd_pkg::CSR_ADDR_W-1:2] == bmd_pkg::REG_LUMA_THRESHOLD);
   assign thr_rd   = csr_psel && !csr_pwrite
                  && (csr_paddr[bmd_pkg::CSR_ADDR_W-1:2] == bmd_pkg::REG_LUMA_THRESHOLD);

   `BMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp transaction changed while stalled")
   `BMD_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid, "rsp_tvalid high after reset")
   `BMD_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_tvalid && !req_xfer && !$past(req_xfer), !rsp_tvalid, "result without a pixel")
   `BMD_ASSERT(a_thr_readback, clock, reset, thr_wr ##1 thr_rd, csr_prdata[bmd_pkg::THR_W-1:0] == $past(csr_pwdata[bmd_pkg::THR_W-1:0]), "threshold readback mismatch")

endmodule

bind binarize_majority_downscale bmd_checker u_bmd_checker (.*);

`default_nettype wire

FILE: tb/tb_binarize_majority_downscale.sv
`timescale 1ns / 1ps

module tb_binarize_majority_downscale;
   import bmd_pkg::*;

   localparam int MAX_SIDE        = 1024;
   localparam int MAX_OUT         = 32;
   localparam int SETTLE_CYCLES   = 6;
   localparam int LONG_STALL      = 80;
   localparam int PIXEL_TARGET    = 1320;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int MAX_REPORTS     = 40;
   localparam int DIRECTED_COUNT  = 31;

   localparam logic [2:0] REG_IDX_UNUSED_A = 3'd5;
   localparam logic [2:0] REG_IDX_UNUSED_B = 3'd7;

   typedef struct packed {
      logic       majority;
      logic [4:0] row;
      logic [4:0] col;
      logic       frame_end;
   } bitmap_cell_t;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} step_kind_e;

   typedef struct packed {
      step_kind_e   kind;
      logic [2:0]   reg_idx;
      logic [31:0]  wdata;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic         typed;
      bitmap_cell_t cell_want;
   } stimulus_row_t;

   localparam bitmap_cell_t NO_RESULT = '0;
   localparam bitmap_cell_t ONE_CELL_SET =
      '{majority: 1'b1, row: 5'd0, col: 5'd0, frame_end: 1'b1};
   localparam bitmap_cell_t ONE_CELL_CLEAR =
      '{majority: 1'b0, row: 5'd0, col: 5'd0, frame_end: 1'b1};

   localparam stimulus_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ROW_WRITE, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SRC_WIDTH,      32'd1,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_DST_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_DST_WIDTH,      32'd63,    8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd255, 8'd255, 1'b1, ONE_CELL_SET},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b1, ONE_CELL_CLEAR},
      '{ROW_WRITE, REG_LUMA_THRESHOLD, 32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b1, ONE_CELL_SET},
      '{ROW_WRITE, REG_LUMA_THRESHOLD, 32'd255,   8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd255, 8'd255, 1'b1, ONE_CELL_CLEAR},
      '{ROW_WRITE, REG_LUMA_THRESHOLD, 32'd200,   8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd200, 8'd200, 8'd200, 1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd201, 8'd201, 8'd201, 1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd255, 8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd255, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_IDX_UNUSED_A,   32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_IDX_UNUSED_B,   32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd255, 8'd255, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SRC_WIDTH,      32'd2,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_DST_WIDTH,      32'd1,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_DST_HEIGHT,     32'd63,    8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SRC_HEIGHT,     32'd2047,  8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SRC_WIDTH,      32'd2047,  8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_DST_WIDTH,      32'd63,    8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
      '{ROW_PIXEL, REG_SRC_HEIGHT,     32'd0,     8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT}
   };

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;  // red, green, blue
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;       // cell_bit, cell_row, cell_col
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   logic [10:0] cfg_src_h, cfg_src_w;
   logic [5:0]  cfg_dst_h, cfg_dst_w;
   logic [7:0]  cfg_thr;
   logic [10:0] eff_rows, eff_cols;
   logic [5:0]  eff_out_rows, eff_out_cols;
   logic signed [21:0] tally [MAX_OUT];
   logic [9:0]  in_row, in_col;
   logic [4:0]  out_row, out_col;
   logic [16:0] row_edge, row_pos, col_edge, col_pos;

   bitmap_cell_t expected_cells [$];
   bitmap_cell_t want, got;
   int errors = 0;
   int cells_checked = 0;
   int pixels_sent = 0;
   int registers_written = 0;
   int geometries = 0;
   int stalls_asked = 0;
   int stalls_done = 0;
   bit no_idle = 1'b0;

   binarize_majority_downscale uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void check_field(input string what, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      end
   endfunction

   function automatic void reload_geometry();
      logic [10:0] lim;
      eff_rows = (cfg_src_h == 0) ? 11'd1 : (cfg_src_h > MAX_SIDE) ? 11'(MAX_SIDE) : cfg_src_h;
      eff_cols = (cfg_src_w == 0) ? 11'd1 : (cfg_src_w > MAX_SIDE) ? 11'(MAX_SIDE) : cfg_src_w;
      lim = (eff_rows < MAX_OUT) ? eff_rows : 11'(MAX_OUT);
      eff_out_rows = (cfg_dst_h == 0) ? 6'd1 : (cfg_dst_h > lim) ? lim[5:0] : cfg_dst_h;
      lim = (eff_cols < MAX_OUT) ? eff_cols : 11'(MAX_OUT);
      eff_out_cols = (cfg_dst_w == 0) ? 6'd1 : (cfg_dst_w > lim) ? lim[5:0] : cfg_dst_w;
      foreach (tally[k]) tally[k] = '0;
      in_row = '0;
      in_col = '0;
      out_row = '0;
      out_col = '0;
      row_edge = 17'(2 * eff_rows + eff_out_rows);
      row_pos = 17'(2 * eff_out_rows);
      col_edge = 17'(2 * eff_cols + eff_out_cols);
      col_pos = 17'(2 * eff_out_cols);
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         REG_SRC_HEIGHT: begin
            cfg_src_h = val[10:0];
            reload_geometry();
         end
         REG_SRC_WIDTH: begin
            cfg_src_w = val[10:0];
            reload_geometry();
         end
         REG_DST_HEIGHT: begin
            cfg_dst_h = val[5:0];
            reload_geometry();
         end
         REG_DST_WIDTH: begin
            cfg_dst_w = val[5:0];
            reload_geometry();
         end
         REG_LUMA_THRESHOLD: cfg_thr = val[7:0];
         default: ;
      endcase
   endfunction

   // Accumulates one pixel into its column tally and returns 1 when it closes a cell.
   function automatic bit shrink_pixel(input logic [7:0] red, input logic [7:0] green,
                                       input logic [7:0] blue, output bitmap_cell_t res);
      int unsigned luma;
      bit is_one, row_closes, col_closes, emits;
      logic [4:0] slot;
      luma = 2989 * red + 5870 * green + 1140 * blue;
      is_one = luma >= cfg_thr * 10000;
      row_closes = (row_pos + 2 * eff_out_rows) > row_edge;
      col_closes = (col_pos + 2 * eff_out_cols) > col_edge;
      slot = out_col;
      tally[slot] = tally[slot] + (is_one ? 1 : -1);
      emits = row_closes && col_closes;
      res = '0;
      if (emits) begin
         res.majority = tally[slot] > 0;
         res.row = out_row;
         res.col = out_col;
         res.frame_end = (out_row + 1 >= eff_out_rows) && (out_col + 1 >= eff_out_cols);
         tally[slot] = '0;
      end
      if (in_col + 1 >= eff_cols) begin
         in_col = '0;
         out_col = '0;
         col_edge = 17'(2 * eff_cols + eff_out_cols);
         col_pos = 17'(2 * eff_out_cols);
         if (in_row + 1 >= eff_rows) begin
            reload_geometry();
         end else begin
            in_row++;
            row_pos = row_pos + 17'(2 * eff_out_rows);
            if (row_closes) begin
               out_row++;
               row_edge = row_edge + 17'(2 * eff_rows);
            end
         end
      end else begin
         in_col++;
         col_pos = col_pos + 17'(2 * eff_out_cols);
         if (col_closes) begin
            out_col++;
            col_edge = col_edge + 17'(2 * eff_cols);
         end
      end
      return emits;
   endfunction

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
      logic [31:0] stored;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      apply_register(idx, val);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_SRC_HEIGHT:     stored = {21'd0, cfg_src_h};
         REG_SRC_WIDTH:      stored = {21'd0, cfg_src_w};
         REG_DST_HEIGHT:     stored = {26'd0, cfg_dst_h};
         REG_DST_WIDTH:      stored = {26'd0, cfg_dst_w};
         REG_LUMA_THRESHOLD: stored = {24'd0, cfg_thr};
         default:            stored = '0;
      endcase
      if (idx <= REG_LUMA_THRESHOLD) check_field("register readback", stored, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      registers_written++;
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input bit use_typed,
                             input bitmap_cell_t typed_cell);
      int gap;
      bitmap_cell_t predicted;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (shrink_pixel(red, green, blue, predicted))
         expected_cells.push_back(use_typed ? typed_cell : predicted);
      pixels_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_cells.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result transaction, expected none, actual %h/%b",
                        $time, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_cells.pop_front();
            got = '{rsp_tdata[0], rsp_tdata[5:1], rsp_tdata[10:6], rsp_tlast};
            check_field("cell_bit", want.majority, got.majority);
            check_field("cell_row", want.row, got.row);
            check_field("cell_col", want.col, got.col);
            check_field("frame_done", want.frame_end, got.frame_end);
            check_field("tdata padding", 0, rsp_tdata[RSP_TDATA_W-1:11]);
         end
         cells_checked++;
      end
   end

   initial begin
      int gap;
      forever begin
         if (stalls_done < stalls_asked) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stalls_done++;
         end
         gap = no_idle ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (reset || rsp_tvalid !== 1'b1);
      end
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      stimulus_row_t step;
      logic [10:0] sh, sw;
      logic [5:0]  dh, dw;
      logic [7:0]  thr, red, green, blue;
      logic [31:0] rgb;
      int mode, count, level, waited;
      bit pressure;

      cfg_src_h = 11'd240;
      cfg_src_w = 11'd160;
      cfg_dst_h = 6'd24;
      cfg_dst_w = 6'd16;
      cfg_thr = 8'd200;
      reload_geometry();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         step = DIRECTED_ROWS[k];
         if (step.kind == ROW_WRITE) begin
            settle_block();
            write_register(step.reg_idx, step.wdata);
         end else begin
            send_pixel(step.red, step.green, step.blue, step.typed, step.cell_want);
         end
      end

      while (pixels_sent < PIXEL_TARGET) begin
         geometries++;
         pressure = (geometries == 1) || ($urandom_range(0, 11) == 0);
         no_idle = pressure || ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 9);
         if (pressure) begin
            sh = 11'd1;
            sw = 11'd1;
            dh = 6'd1;
            dw = 6'd1;
         end else if (mode == 0) begin
            sh = 11'($urandom_range(0, 2047));
            sw = 11'($urandom_range(0, 2047));
            dh = 6'($urandom_range(0, 63));
            dw = 6'($urandom_range(0, 63));
         end else if (mode == 1) begin
            sh = 11'($urandom_range(1, 3));
            sw = 11'($urandom_range(32, 40));
            dh = 6'($urandom_range(1, 3));
            dw = 6'd32;
         end else if (mode == 2) begin
            sh = 11'($urandom_range(32, 40));
            sw = 11'($urandom_range(1, 3));
            dh = 6'd32;
            dw = 6'($urandom_range(1, 3));
         end else if (mode == 3) begin
            sh = 11'($urandom_range(1, 2));
            sw = $urandom_range(0, 1) ? 11'd1024 : 11'($urandom_range(1025, 2047));
            dh = 6'd1;
            dw = 6'($urandom_range(1, 32));
         end else begin
            sh = 11'($urandom_range(1, 12));
            sw = 11'($urandom_range(1, 12));
            dh = 6'($urandom_range(0, sh + 1));
            dw = 6'($urandom_range(0, sw + 1));
         end

         settle_block();
         write_register(REG_SRC_HEIGHT, {21'($urandom()), sh});
         write_register(REG_SRC_WIDTH, {21'($urandom()), sw});
         write_register(REG_DST_HEIGHT, {26'($urandom()), dh});
         write_register(REG_DST_WIDTH, {26'($urandom()), dw});
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0:       thr = 8'd0;
               1:       thr = 8'd255;
               default: thr = 8'($urandom());
            endcase
            write_register(REG_LUMA_THRESHOLD, {24'($urandom()), thr});
         end

         if (pressure) begin
            count = 60;
            stalls_asked++;
         end else if (mode == 3) begin
            count = $urandom_range(60, 150);
         end else begin
            count = eff_rows * eff_cols * $urandom_range(1, 2) + $urandom_range(0, 3);
            if (count > 200) count = $urandom_range(60, 150);
         end

         for (int i = 0; i < count; i++) begin
            if (pressure && i == 40) begin
               settle_block();
            end else if (!pressure && count > 1 && i == count / 2) begin
               case ($urandom_range(0, 5))
                  0: begin
                     settle_block();
                     write_register(REG_LUMA_THRESHOLD, $urandom());
                  end
                  1: begin
                     settle_block();
                     write_register($urandom_range(0, 1) ? REG_IDX_UNUSED_A : REG_IDX_UNUSED_B,
                                    $urandom());
                  end
                  2: settle_block();
                  default: ;
               endcase
            end
            if ($urandom_range(0, 3) == 0) begin
               level = int'(cfg_thr) + int'($urandom_range(0, 4)) - 2;
               if (level < 0) level = 0;
               if (level > 255) level = 255;
               red = 8'(level);
               green = 8'(level);
               blue = 8'(level);
            end else begin
               rgb = $urandom();
               red = rgb[7:0];
               green = rgb[15:8];
               blue = rgb[23:16];
            end
            send_pixel(red, green, blue, 1'b0, NO_RESULT);
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_cells.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_cells.size() != 0) begin
         errors += expected_cells.size();
         $display("%0t: %0d expected cells never arrived, expected 0 outstanding, actual %0d",
                  $time, expected_cells.size(), expected_cells.size());
      end

      $display("Run covered %0d pixels over %0d frame geometries and %0d register writes.",
               pixels_sent, geometries, registers_written);
      $display("It compared %0d output cells and held the result side off %0d times.",
               cells_checked, stalls_done);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/bmd_pkg.sv
design/bmd_ram.sv
design/binarize_majority_downscale.sv
design/bmd_checker.sv
tb/tb_binarize_majority_downscale.sv
